### rtl/fpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Types and codes shared by the framed packet parser blocks.
// ----------------------------------------------------------------------------
package fpp_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OK_CODE      = 2'd2;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h55;
	localparam logic [BYTE_W-1:0] STOP_MARKER_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] OK_CODE_RST      = 8'hFF;
	localparam logic [BYTE_W-1:0] REPLY_LEN        = 8'h00;

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_STOP = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		BEAT_ECHO  = 3'd0,
		BEAT_START = 3'd1,
		BEAT_OK    = 3'd2,
		BEAT_LEN   = 3'd3,
		BEAT_STOP  = 3'd4
	} beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] stop_marker;
		logic [BYTE_W-1:0] ok_code;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] echo;
		logic              ack;
	} parse_t;

endpackage

### rtl/fpp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_parser
// Packet recognizer: phase and data count, updated once per byte.
// ----------------------------------------------------------------------------
module fpp_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [fpp_pkg::BYTE_W-1:0] rx_s1,
	input  fpp_pkg::cfg_t              cfg,
	output fpp_pkg::parse_t            res
);
	import fpp_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [BYTE_W-1:0] left_dec;

	assign left_dec = bytes_left_q - 8'd1;

	// next state
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		unique case (phase_q)
			PH_CMD: phase_d = PH_LEN;
			PH_LEN: begin
				bytes_left_d = rx_s1;
				phase_d      = (rx_s1 == '0) ? PH_STOP : PH_DATA;
			end
			PH_DATA: begin
				bytes_left_d = left_dec;
				if (left_dec == '0) phase_d = PH_STOP;
			end
			PH_STOP: phase_d = PH_WAIT;
			default: phase_d = (rx_s1 == cfg.start_marker) ? PH_CMD : PH_WAIT;
		endcase
	end

	// outputs
	always_comb begin
		res.echo = rx_s1;
		res.ack  = (phase_q == PH_STOP) && (rx_s1 == cfg.stop_marker);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			bytes_left_q <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (bytes_left_q != '0))
		else $error("data phase with no bytes left");
	a_stop_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_STOP) |=> (phase_q == PH_WAIT))
		else $error("stop phase did not return to wait");
`endif

endmodule

### rtl/fpp_reply_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_reply_seq
// Output register: echo beat, then the four acknowledge beats on a match.
// ----------------------------------------------------------------------------
module fpp_reply_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  fpp_pkg::parse_t            res,
	input  fpp_pkg::cfg_t              cfg,
	output logic                       out_free,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fpp_pkg::BYTE_W-1:0] tx_byte,
	output logic                       is_reply,
	output logic                       last
);
	import fpp_pkg::*;

	logic              valid_q;
	beat_t             beat_q;
	logic              ack_q;
	logic [BYTE_W-1:0] echo_q;

	assign out_valid = valid_q;
	assign out_free  = !valid_q || (out_ready && last);

	always_comb begin
		unique case (beat_q)
			BEAT_ECHO:  tx_byte = echo_q;
			BEAT_START: tx_byte = cfg.start_marker;
			BEAT_OK:    tx_byte = cfg.ok_code;
			BEAT_LEN:   tx_byte = REPLY_LEN;
			BEAT_STOP:  tx_byte = cfg.stop_marker;
			default:    tx_byte = echo_q;
		endcase
		is_reply = (beat_q != BEAT_ECHO);
		last     = (beat_q == BEAT_STOP) || (beat_q == BEAT_ECHO && !ack_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= BEAT_ECHO;
			ack_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= BEAT_ECHO;
			ack_q   <= res.ack;
		end else if (valid_q && out_ready) begin
			if (last) valid_q <= 1'b0;
			else beat_q <= beat_t'(beat_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) echo_q <= res.echo;
	end

`ifndef NO_ASSERTIONS
	a_reply_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && beat_q != BEAT_ECHO) |-> ack_q)
		else $error("reply beat without acknowledge");
	a_reply_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_ready && !last) |=> valid_q)
		else $error("reply cut short");
`endif

endmodule

### rtl/framed_packet_parser_with_ack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_with_ack_unit
// Byte echo with start/cmd/len/data/stop packet recognizer and acknowledge.
// ----------------------------------------------------------------------------
// Each received byte is echoed as one result. When a byte closes a packet with
// the stop marker, four reply bytes follow (start, ok code, zero length, stop),
// with last set on the final one. One byte is taken per cycle while results
// flow; a completing byte holds the output register for its echo and the four
// reply beats, and one more byte waits in the input register meanwhile.
// Configuration writes are always ready and should be made idle.
module framed_packet_parser_with_ack_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fpp_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fpp_pkg::BYTE_W-1:0]    tx_byte,
	output logic                          is_reply,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpp_pkg::BYTE_W-1:0]    cfg_data
);
	import fpp_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              load;
	parse_t            res;

	assign cfg_ready = 1'b1;
	assign load      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= START_MARKER_RST;
			cfg_q.stop_marker  <= STOP_MARKER_RST;
			cfg_q.ok_code      <= OK_CODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_MARKER: cfg_q.start_marker <= cfg_data;
				REG_STOP_MARKER:  cfg_q.stop_marker  <= cfg_data;
				REG_OK_CODE:      cfg_q.ok_code      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ready) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	fpp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(load),
		.rx_s1  (byte_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	fpp_reply_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.cfg      (cfg_q),
		.out_free (out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte  (tx_byte),
		.is_reply (is_reply),
		.last     (last)
	);

`ifndef NO_ASSERTIONS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input request lost");
`endif

endmodule

### verif/framed_packet_parser_with_ack_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_with_ack_unit_tb
// Self-checking bench for the byte echo and packet acknowledge unit.
// ----------------------------------------------------------------------------
// A queue of received bytes feeds a valid/ready driver. Each accepted byte is
// run through a packet tracker, which keeps its own phase, length count and
// marker settings and pushes the echo and any acknowledge bytes it implies.
// A monitor pops these in order and compares every field of each result. The
// run goes through several marker settings and several idle/stall patterns.
// ----------------------------------------------------------------------------
module framed_packet_parser_with_ack_unit_tb;
	import fpp_pkg::*;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              reply;
		logic              fin;
	} tx_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    tx_byte;
	logic                 is_reply;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data = '0;

	framed_packet_parser_with_ack_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.is_reply(is_reply),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// tracker state and its copy of the marker registers
	phase_t            trk_phase = PH_WAIT;
	logic [BYTE_W-1:0] trk_left = '0;
	logic [BYTE_W-1:0] cur_start = START_MARKER_RST;
	logic [BYTE_W-1:0] cur_stop = STOP_MARKER_RST;
	logic [BYTE_W-1:0] cur_ok = OK_CODE_RST;

	logic [BYTE_W-1:0] rx_pending_q[$];
	tx_beat_t          tx_beats_q[$];
	int                idle_mode = IDLE_NONE;
	bit                in_fired = 1'b0;
	int                mismatches = 0;
	int                bytes_in = 0;
	int                beats_checked = 0;
	int                acks_seen = 0;
	int                reg_writes = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	task automatic track_packet(input logic [BYTE_W-1:0] b);
		logic ack;
		ack = 1'b0;
		case (trk_phase)
			PH_CMD: trk_phase = PH_LEN;
			PH_LEN: begin
				trk_left = b;
				trk_phase = (b == 8'd0) ? PH_STOP : PH_DATA;
			end
			PH_DATA: begin
				trk_left = trk_left - 8'd1;
				if (trk_left == 8'd0)
					trk_phase = PH_STOP;
			end
			PH_STOP: begin
				ack = (b == cur_stop);
				trk_phase = PH_WAIT;
			end
			default: trk_phase = (b == cur_start) ? PH_CMD : PH_WAIT;
		endcase
		tx_beats_q.push_back('{data: b, reply: 1'b0, fin: !ack});
		if (ack) begin
			acks_seen++;
			tx_beats_q.push_back('{data: cur_start, reply: 1'b1, fin: 1'b0});
			tx_beats_q.push_back('{data: cur_ok, reply: 1'b1, fin: 1'b0});
			tx_beats_q.push_back('{data: REPLY_LEN, reply: 1'b1, fin: 1'b0});
			tx_beats_q.push_back('{data: cur_stop, reply: 1'b1, fin: 1'b1});
		end
	endtask

	task automatic check_beat();
		tx_beat_t want;
		if (tx_beats_q.size() == 0) begin
			report_mismatch("result with nothing expected, tx_byte", tx_byte, 0);
		end else begin
			want = tx_beats_q.pop_front();
			beats_checked++;
			if (tx_byte !== want.data)
				report_mismatch("tx_byte", tx_byte, want.data);
			if (is_reply !== want.reply)
				report_mismatch("is_reply", is_reply, want.reply);
			if (last !== want.fin)
				report_mismatch("last", last, want.fin);
		end
	endtask

	function automatic bit sender_rests();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 75;
			IDLE_BOTH: return $urandom_range(99) < 20;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 75;
			IDLE_BOTH: return $urandom_range(99) < 20;
			default:   return 1'b0;
		endcase
	endfunction

	// handshakes seen at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_fired = 1'b1;
				bytes_in++;
				track_packet(rx_byte);
			end
			if (out_valid && out_ready)
				check_beat();
		end
	end

	// request driver: new byte only once the current one has gone
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fired)) begin
			in_fired = 1'b0;
			if (rx_pending_q.size() != 0 && !sender_rests()) begin
				rx_byte <= rx_pending_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= !receiver_stalls();
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_START_MARKER: cur_start = val;
			REG_STOP_MARKER:  cur_stop = val;
			REG_OK_CODE:      cur_ok = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] p,
			input logic [BYTE_W-1:0] o);
		write_reg(REG_START_MARKER, s);
		write_reg(REG_STOP_MARKER, p);
		write_reg(REG_OK_CODE, o);
	endtask

	task automatic queue_packet(input int len, input bit good_stop);
		rx_pending_q.push_back(cur_start);
		rx_pending_q.push_back(8'($urandom));
		rx_pending_q.push_back(8'(len));
		repeat (len) rx_pending_q.push_back(8'($urandom));
		rx_pending_q.push_back(good_stop ? cur_stop : 8'($urandom));
	endtask

	// mostly well-formed packets with random content, some loose bytes
	task automatic queue_random(input int n);
		int added;
		int len;
		added = 0;
		while (added < n) begin
			if ($urandom_range(9) < 8) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4);
				queue_packet(len, $urandom_range(9) != 0);
				added += len + 4;
			end else begin
				rx_pending_q.push_back(8'($urandom));
				added++;
			end
		end
	endtask

	task automatic wait_drained();
		while (rx_pending_q.size() != 0 || in_valid || tx_beats_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int mode, input int n);
		idle_mode = mode;
		queue_random(n);
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed bytes under reset markers
		idle_mode = IDLE_NONE;
		rx_pending_q = '{8'h00, 8'hFF,
			8'h55, 8'h01, 8'h00, 8'hAA,               // zero length, acknowledged
			8'h55, 8'hFF, 8'h01, 8'h00, 8'hAA,        // one data byte
			8'h55, 8'h7E, 8'h02, 8'hFF, 8'h80, 8'hAA, // two data bytes
			8'h55, 8'h00, 8'h00, 8'h3C,               // wrong stop byte, no reply
			8'hAA};                                   // stop value while waiting
		wait_drained();
		run_phase(IDLE_NONE, 12);

		set_markers(8'h00, 8'hFF, 8'h00);
		idle_mode = IDLE_SEND;
		queue_packet(24, 1'b1);
		run_phase(IDLE_SEND, 15);

		set_markers(8'hFF, 8'h00, 8'h80);
		run_phase(IDLE_RECV, 15);

		set_markers(8'($urandom), 8'($urandom), 8'($urandom));
		run_phase(IDLE_BOTH, 15);

		// same value opens and closes a packet
		set_markers(8'h3C, 8'h3C, 8'hC3);
		run_phase(IDLE_BOTH, 12);

		$display("Covered %0d input bytes, %0d results checked, %0d acknowledges.",
			bytes_in, beats_checked, acks_seen);
		$display("Used %0d register writes across five marker settings and four idle patterns.",
			reg_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
